// ===== sv/tile_grid_rle_decoder_core_defines.svh =====
// Assertion macros shared by the checker files.
// They expect clk and arst_n to be visible where they are used.
`ifndef TILE_GRID_RLE_DECODER_CORE_DEFINES_SVH
`define TILE_GRID_RLE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tgr: same-cycle rule violated");

// Next-cycle implication, disabled while reset is asserted.
`define TGR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tgr: next-cycle rule violated");

`endif

// ===== sv/tgr_pkg.sv =====
package tgr_pkg;

	// tile store size; a grid larger than this many tiles is flagged as a size error
	localparam int unsigned MaxTiles = 65536;
	// tile counters hold 0..MaxTiles
	localparam int unsigned TileCntW = $clog2(MaxTiles + 1);
	localparam int unsigned ProdW    = 2 * TileCntW;

	// format_mode codes
	localparam logic [1:0] MODE_RAW   = 2'd0;
	localparam logic [1:0] MODE_RLE   = 2'd1;
	localparam logic [1:0] MODE_ALIGN = 2'd2;

	// configuration register indexes
	localparam logic REG_FORMAT_MODE = 1'b0;
	localparam logic REG_START_PHASE = 1'b1;

	localparam logic [3:0] PadBytes = 4'd5;

	typedef enum logic [6:0] {
		PH_HDR  = 7'b0000001,
		PH_CALC = 7'b0000010,
		PH_RAW  = 7'b0000100,
		PH_CTRL = 7'b0001000,
		PH_REP  = 7'b0010000,
		PH_LIT  = 7'b0100000,
		PH_SKIP = 7'b1000000
	} phase_t;

	// one classified command from the parser to the expander
	typedef struct packed {
		logic        is_header;
		logic        size_error;
		logic        last;
		logic [31:0] background;
		logic [31:0] columns;
		logic [31:0] rows;
		logic [31:0] word;
		logic [7:0]  run;
		logic [15:0] idx;
	} cmd_t;

	typedef struct packed {
		logic        is_header;
		logic [31:0] background;
		logic [31:0] columns;
		logic [31:0] rows;
		logic        size_error;
		logic [31:0] tile_first;
		logic [31:0] tile_second;
		logic [1:0]  tile_count;
		logic [15:0] first_index;
		logic        last;
	} res_t;

	// handshake between the command queue and its neighbors
	typedef struct packed {
		logic push;
		logic full;
		logic pop;
		logic empty;
	} q_ctl_t;

endpackage

// ===== sv/tgr_front.sv =====
module tgr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic          cfg_addr,
	input  logic [1:0]    cfg_wdata,
	input  logic          push,
	input  logic [7:0]    data_byte,
	output logic          full,
	output logic          cmd_push,
	input  logic          cmd_full,
	output tgr_pkg::cmd_t cmd
);
	import tgr_pkg::*;

	phase_t              phase_q;
	logic [3:0]          byte_cnt_q;
	logic [31:0]         word_q;
	logic [31:0]         hdr_bg_q;
	logic [31:0]         hdr_cols_q;
	logic [31:0]         hdr_rows_q;
	logic [TileCntW-1:0] total_q;
	logic [TileCntW-1:0] produced_q;
	logic [7:0]          pending_q;
	logic [31:0]         newest_q;
	logic [3:0]          skip_q;
	logic [1:0]          pos_q;
	logic [1:0]          mode_q;

	logic                accept;
	logic                word_phase;
	logic                word_done;
	logic [1:0]          pos_nxt;
	logic [31:0]         word_nxt;
	logic                cols_big;
	logic                rows_big;
	logic                grid_zero;
	logic [ProdW-1:0]    prod;
	logic                size_err;
	logic [TileCntW-1:0] total_calc;
	logic [TileCntW-1:0] left;
	logic [7:0]          ctrl_raw;
	logic [7:0]          ctrl_run;
	logic [7:0]          run_w;
	logic [TileCntW-1:0] produced_nxt;
	logic                dup;
	logic                differ;
	logic [3:0]          skip_pad;
	logic [1:0]          align_gap;
	logic [3:0]          skip_all;
	logic                tiles_done;

	assign full       = cmd_full || (phase_q == PH_CALC);
	assign accept     = push && !full;
	assign word_phase = (phase_q == PH_RAW) || (phase_q == PH_REP) || (phase_q == PH_LIT);
	assign word_done  = (byte_cnt_q[1:0] == 2'd3);
	assign pos_nxt    = pos_q + 2'd1;
	assign word_nxt   = word_q | (32'(data_byte) << {byte_cnt_q[1:0], 3'b000});

	// grid size check: both factors at most MaxTiles, then a narrow product
	assign cols_big   = hdr_cols_q > 32'(MaxTiles);
	assign rows_big   = hdr_rows_q > 32'(MaxTiles);
	assign grid_zero  = (hdr_cols_q == 32'd0) || (hdr_rows_q == 32'd0);
	assign prod       = ProdW'(hdr_cols_q[TileCntW-1:0]) * ProdW'(hdr_rows_q[TileCntW-1:0]);
	assign size_err   = !grid_zero && (cols_big || rows_big || (prod > ProdW'(MaxTiles)));
	assign total_calc = (size_err || grid_zero) ? '0 : prod[TileCntW-1:0];

	// control byte: run clipped to the tiles still missing
	assign left     = total_q - produced_q;
	assign ctrl_raw = data_byte[7] ? ({1'b0, data_byte[6:0]} + 8'd1) : data_byte;
	assign ctrl_run = (32'(ctrl_raw) > 32'(left)) ? 8'(left) : ctrl_raw;

	assign run_w        = (phase_q == PH_REP) ? pending_q : 8'd1;
	assign produced_nxt = produced_q + TileCntW'(run_w);
	assign tiles_done   = produced_nxt >= total_q;

	// pad and alignment skip after the last coded tile
	// a doubled tile leaves the last two equal
	assign dup       = (phase_q == PH_REP) && (run_w >= 8'd2);
	assign differ    = !dup && (newest_q != word_nxt);
	assign skip_pad  = ((total_q == TileCntW'(1)) || differ) ? PadBytes : 4'd0;
	assign align_gap = 2'd0 - (pos_nxt + skip_pad[1:0]);
	assign skip_all  = skip_pad + ((mode_q >= MODE_ALIGN) ? {2'b00, align_gap} : 4'd0);

	assign cmd_push = ((phase_q == PH_CALC) && !cmd_full) || (accept && word_phase && word_done);

	always_comb begin
		cmd.is_header  = (phase_q == PH_CALC);
		cmd.size_error = size_err;
		cmd.last       = (phase_q == PH_CALC) ? (total_calc == '0) : (produced_nxt == total_q);
		cmd.background = hdr_bg_q;
		cmd.columns    = hdr_cols_q;
		cmd.rows       = hdr_rows_q;
		cmd.word       = word_nxt;
		cmd.run        = run_w;
		cmd.idx        = 16'(produced_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HDR;
			byte_cnt_q <= '0;
			word_q     <= '0;
			hdr_bg_q   <= '0;
			hdr_cols_q <= '0;
			hdr_rows_q <= '0;
			total_q    <= '0;
			produced_q <= '0;
			pending_q  <= '0;
			newest_q   <= '0;
			skip_q     <= '0;
			pos_q      <= 2'd0;
			mode_q     <= MODE_RLE;
		end else begin
			if (cfg_wr_en && (cfg_addr == REG_START_PHASE)) begin
				pos_q <= cfg_wdata;
			end else if (accept) begin
				pos_q <= pos_nxt;
			end
			case (phase_q)
				PH_HDR: begin
					if (accept) begin
						word_q <= word_done ? 32'd0 : word_nxt;
						if (byte_cnt_q == 4'd3) begin
							hdr_bg_q <= word_nxt;
						end
						if (byte_cnt_q == 4'd7) begin
							hdr_cols_q <= word_nxt;
						end
						if (byte_cnt_q == 4'd11) begin
							hdr_rows_q <= word_nxt;
							byte_cnt_q <= '0;
							phase_q    <= PH_CALC;
						end else begin
							byte_cnt_q <= byte_cnt_q + 4'd1;
						end
					end
				end
				PH_CALC: begin
					if (!cmd_full) begin
						total_q    <= total_calc;
						produced_q <= '0;
						newest_q   <= '0;
						pending_q  <= '0;
						if (total_calc == '0) begin
							phase_q <= PH_HDR;
						end else if (mode_q == MODE_RAW) begin
							phase_q <= PH_RAW;
						end else begin
							phase_q <= PH_CTRL;
						end
					end
				end
				PH_CTRL: begin
					if (accept) begin
						pending_q <= ctrl_run;
						if (data_byte[7]) begin
							phase_q <= PH_REP;
						end else if (ctrl_run != 8'd0) begin
							phase_q <= PH_LIT;
						end
					end
				end
				PH_RAW, PH_REP, PH_LIT: begin
					if (accept) begin
						if (!word_done) begin
							word_q     <= word_nxt;
							byte_cnt_q <= byte_cnt_q + 4'd1;
						end else begin
							word_q     <= '0;
							byte_cnt_q <= '0;
							produced_q <= produced_nxt;
							newest_q   <= word_nxt;
							if (phase_q == PH_LIT) begin
								pending_q <= pending_q - 8'd1;
							end
							if (phase_q == PH_RAW) begin
								if (tiles_done) begin
									phase_q <= PH_HDR;
								end
							end else if (tiles_done) begin
								skip_q  <= skip_all;
								phase_q <= (skip_all == 4'd0) ? PH_HDR : PH_SKIP;
							end else if ((phase_q == PH_REP) || (pending_q == 8'd1)) begin
								phase_q <= PH_CTRL;
							end
						end
					end
				end
				PH_SKIP: begin
					if (accept) begin
						skip_q <= skip_q - 4'd1;
						if (skip_q == 4'd1) begin
							phase_q <= PH_HDR;
						end
					end
				end
				default: begin
					phase_q <= PH_HDR;
				end
			endcase
			// the user must write configuration only while idle; the block itself does not enforce it
			if (cfg_wr_en && (cfg_addr == REG_FORMAT_MODE)) begin
				mode_q <= cfg_wdata;
			end
		end
	end

endmodule

// ===== sv/tgr_cmd_q.sv =====
module tgr_cmd_q (
	input  logic           clk,
	input  logic           arst_n,
	input  tgr_pkg::q_ctl_t ctl_in,
	output tgr_pkg::q_ctl_t ctl_out,
	input  tgr_pkg::cmd_t  wr_data,
	output tgr_pkg::cmd_t  rd_data
);
	import tgr_pkg::*;

	cmd_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign do_push = ctl_in.push && (cnt_q != 2'd2);
	assign do_pop  = ctl_in.pop && (cnt_q != 2'd0);

	always_comb begin
		ctl_out       = ctl_in;
		ctl_out.full  = (cnt_q == 2'd2);
		ctl_out.empty = (cnt_q == 2'd0);
	end

	assign rd_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/tgr_back.sv =====
module tgr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_empty,
	input  tgr_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          empty,
	input  logic          pop,
	output tgr_pkg::res_t res
);
	import tgr_pkg::*;

	logic [7:0] done_q;
	logic [7:0] rem;
	logic       two;
	logic       cmd_end;
	logic       emit;
	res_t       res_nxt;

	res_t       slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       rq_full;
	logic       do_pop;

	// a repeat command is expanded two tiles per result, the last result of an odd run carrying one
	assign rem     = cmd.run - done_q;
	assign two     = !cmd.is_header && (rem >= 8'd2);
	assign cmd_end = cmd.is_header || (rem <= 8'd2);
	assign rq_full = (cnt_q == 2'd2);
	assign emit    = !cmd_empty && !rq_full;
	assign cmd_pop = emit && cmd_end;

	always_comb begin
		res_nxt.is_header   = cmd.is_header;
		res_nxt.background  = cmd.is_header ? cmd.background : 32'd0;
		res_nxt.columns     = cmd.is_header ? cmd.columns : 32'd0;
		res_nxt.rows        = cmd.is_header ? cmd.rows : 32'd0;
		res_nxt.size_error  = cmd.is_header && cmd.size_error;
		res_nxt.tile_first  = cmd.is_header ? 32'd0 : cmd.word;
		res_nxt.tile_second = two ? cmd.word : 32'd0;
		res_nxt.tile_count  = cmd.is_header ? 2'd0 : (two ? 2'd2 : 2'd1);
		res_nxt.first_index = cmd.is_header ? 16'd0 : (cmd.idx + 16'(done_q));
		res_nxt.last        = cmd.last && cmd_end;
	end

	assign empty  = (cnt_q == 2'd0);
	assign do_pop = pop && !empty;
	assign res    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (emit) begin
			slot_q[wr_ptr_q] <= res_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q   <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (emit) begin
				done_q   <= cmd_end ? 8'd0 : (done_q + 8'd2);
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({emit, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== sv/tile_grid_rle_decoder_core.sv =====
// Channel   | Direction | Handshake             | Payload
// ----------+-----------+-----------------------+----------------------------------------
// bytes     | in        | push / full           | data_byte
// results   | out       | empty / pop           | is_header, background_index, columns,
//           |           |                       | rows, size_error, tile_first,
//           |           |                       | tile_second, tile_count, first_index, last
// config    | in        | cfg_wr_en (no wait)   | cfg_addr, cfg_wdata
//
// One byte is taken per cycle while the command queue has room and the size check is not running.
// After the twelfth header byte the parser holds full high in its grid size
// check state (narrow multiply and compare).
// A repeat run of N tiles is expanded in pairs, one result per cycle while the result
// queue has room; a long run fills the two-entry command queue and then stalls input.
// A stalled pop holds the two-entry result queue; the parser keeps going until
// the command queue is full as well.
// arst_n clears all control state; config resets to coded mode, phase zero.
module tile_grid_rle_decoder_core (
	input  logic               clk,
	input  logic               arst_n,
	// configuration
	input  logic               cfg_wr_en,
	input  logic               cfg_addr,
	input  logic [1:0]         cfg_wdata,
	// byte stream in
	input  logic               push,
	output logic               full,
	input  logic [7:0]         data_byte,
	// results out
	output logic               empty,
	input  logic               pop,
	output logic               is_header,
	output logic signed [31:0] background_index,
	output logic [31:0]        columns,
	output logic [31:0]        rows,
	output logic               size_error,
	output logic [31:0]        tile_first,
	output logic [31:0]        tile_second,
	output logic [1:0]         tile_count,
	output logic [15:0]        first_index,
	output logic               last
);
	import tgr_pkg::*;

	q_ctl_t q_in;
	q_ctl_t q_out;
	cmd_t   cmd_wr;
	cmd_t   cmd_rd;
	res_t   res;
	logic   cmd_push;
	logic   cmd_pop;

	// front: header assembly, control bytes, word assembly, pad/align skip
	tgr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.data_byte (data_byte),
		.full      (full),
		.cmd_push  (cmd_push),
		.cmd_full  (q_out.full),
		.cmd       (cmd_wr)
	);

	always_comb begin
		q_in.push  = cmd_push;
		q_in.pop   = cmd_pop;
		q_in.full  = 1'b0;
		q_in.empty = 1'b0;
	end

	// short queue of classified commands between parser and expander
	tgr_cmd_q u_cmd_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (q_in),
		.ctl_out (q_out),
		.wr_data (cmd_wr),
		.rd_data (cmd_rd)
	);

	// back: expands runs into paired tile results, holds the result queue
	tgr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_empty (q_out.empty),
		.cmd       (cmd_rd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign is_header        = res.is_header;
	assign background_index = signed'(res.background);
	assign columns          = res.columns;
	assign rows             = res.rows;
	assign size_error       = res.size_error;
	assign tile_first       = res.tile_first;
	assign tile_second      = res.tile_second;
	assign tile_count       = res.tile_count;
	assign first_index      = res.first_index;
	assign last             = res.last;

endmodule

// ===== sv/tgr_checker.sv =====
`include "tile_grid_rle_decoder_core_defines.svh"

module tgr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cfg_wr_en,
	input logic               cfg_addr,
	input logic [1:0]         cfg_wdata,
	input logic               push,
	input logic               full,
	input logic [7:0]         data_byte,
	input logic               empty,
	input logic               pop,
	input logic               is_header,
	input logic signed [31:0] background_index,
	input logic [31:0]        columns,
	input logic [31:0]        rows,
	input logic               size_error,
	input logic [31:0]        tile_first,
	input logic [31:0]        tile_second,
	input logic [1:0]         tile_count,
	input logic [15:0]        first_index,
	input logic               last
);

	// a waiting item stays put until popped
	`TGR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(tile_first) && $stable(first_index))

	// header items carry no tiles, tile items carry one or two
	`TGR_ASSERT_NOW(a_kind, !empty, is_header == (tile_count == 2'd0))

	// a single tile leaves the second word clear
	`TGR_ASSERT_NOW(a_single, !empty && (tile_count == 2'd1), tile_second == 32'd0)

	// an oversized grid is empty, so its header closes the record
	`TGR_ASSERT_NOW(a_err_last, !empty && is_header && size_error, last)

endmodule

bind tile_grid_rle_decoder_core tgr_checker u_tgr_checker (.*);
